// ===== rtl/core/dibi_pkg.sv =====
// ---------------------------------------------------------------------------
// dibi_pkg
// Shared types and codes of the display set-up list interpreter.
// ---------------------------------------------------------------------------
package dibi_pkg;

    localparam logic [7:0] OP_SELECT       = 8'd0;
    localparam logic [7:0] OP_CMD_ONE      = 8'd1;
    localparam logic [7:0] OP_CMD_TWO      = 8'd2;
    localparam logic [7:0] OP_CMD_RUN      = 8'd3;
    localparam logic [7:0] OP_DATA_ONE     = 8'd4;
    localparam logic [7:0] OP_DATA_TWO     = 8'd5;
    localparam logic [7:0] OP_DATA_RUN     = 8'd6;
    localparam logic [7:0] OP_CMD_DATA_ONE = 8'd7;
    localparam logic [7:0] OP_CMD_DATA_TWO = 8'd8;
    localparam logic [7:0] OP_CMD_DATA_RUN = 8'd9;
    localparam logic [7:0] OP_CMD2_DATA2   = 8'd10;
    localparam logic [7:0] OP_RELEASE      = 8'd11;
    localparam logic [7:0] OP_DELAY        = 8'd12;

    typedef enum logic [2:0] {
        ACT_CMD     = 3'd0,
        ACT_DATA    = 3'd1,
        ACT_SELECT  = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_DELAY   = 3'd4
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
    } item_t;

endpackage

// ===== rtl/core/dibi_front.sv =====
// ---------------------------------------------------------------------------
// dibi_front
// List parser: takes one list beat per cycle while in_fire is high and emits at most one action.
// ---------------------------------------------------------------------------
module dibi_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     op_byte,
    input  logic           last_byte,
    output logic           push,
    output dibi_pkg::item_t push_item
);
    import dibi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_CMD        = 3'd1,
        PH_CMD_COUNT  = 3'd2,
        PH_DATA_COUNT = 3'd3,
        PH_DATA       = 3'd4,
        PH_DELAY      = 3'd5
    } phase_t;

    localparam logic [1:0] FOLLOW_NONE  = 2'd0;
    localparam logic [1:0] FOLLOW_COUNT = 2'd3;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [1:0] follow_reg, follow_next;
    logic       emit;
    action_t    emit_action;
    logic [7:0] emit_value;
    logic [7:0] rem_dec;

    assign rem_dec = remaining_reg - 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        follow_next    = follow_reg;
        emit           = 1'b0;
        emit_action    = ACT_CMD;
        emit_value     = op_byte;
        unique case (phase_reg)
            PH_IDLE:
            begin
                unique case (op_byte)
                    OP_SELECT:
                    begin
                        emit        = 1'b1;
                        emit_action = ACT_SELECT;
                        emit_value  = 8'd0;
                    end
                    OP_RELEASE:
                    begin
                        emit        = 1'b1;
                        emit_action = ACT_RELEASE;
                        emit_value  = 8'd0;
                    end
                    OP_CMD_ONE:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd1; follow_next = 2'd0;
                    end
                    OP_CMD_TWO:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd2; follow_next = 2'd0;
                    end
                    OP_CMD_RUN:
                    begin
                        phase_next = PH_CMD_COUNT; remaining_next = 8'd0; follow_next = 2'd0;
                    end
                    OP_DATA_ONE:
                    begin
                        phase_next = PH_DATA; remaining_next = 8'd1; follow_next = 2'd0;
                    end
                    OP_DATA_TWO:
                    begin
                        phase_next = PH_DATA; remaining_next = 8'd2; follow_next = 2'd0;
                    end
                    OP_DATA_RUN:
                    begin
                        phase_next = PH_DATA_COUNT; remaining_next = 8'd0; follow_next = 2'd0;
                    end
                    OP_CMD_DATA_ONE:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd1; follow_next = 2'd1;
                    end
                    OP_CMD_DATA_TWO:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd1; follow_next = 2'd2;
                    end
                    OP_CMD_DATA_RUN:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd1; follow_next = FOLLOW_COUNT;
                    end
                    OP_CMD2_DATA2:
                    begin
                        phase_next = PH_CMD; remaining_next = 8'd2; follow_next = 2'd2;
                    end
                    OP_DELAY:
                    begin
                        phase_next = PH_DELAY; remaining_next = 8'd0; follow_next = 2'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_CMD:
            begin
                emit           = 1'b1;
                emit_action    = ACT_CMD;
                remaining_next = rem_dec;
                if (rem_dec == 8'd0)
                begin
                    priority if (follow_reg == FOLLOW_NONE)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (follow_reg == FOLLOW_COUNT)
                    begin
                        phase_next = PH_DATA_COUNT;
                    end
                    else
                    begin
                        phase_next     = PH_DATA;
                        remaining_next = {6'd0, follow_reg};
                    end
                    follow_next = 2'd0;
                end
            end
            PH_CMD_COUNT, PH_DATA_COUNT:
            begin
                if (op_byte == 8'd0)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = (phase_reg == PH_CMD_COUNT) ? PH_CMD : PH_DATA;
                end
                remaining_next = op_byte;
                follow_next    = 2'd0;
            end
            PH_DATA:
            begin
                emit           = 1'b1;
                emit_action    = ACT_DATA;
                remaining_next = rem_dec;
                if (rem_dec == 8'd0)
                begin
                    phase_next  = PH_IDLE;
                    follow_next = 2'd0;
                end
            end
            PH_DELAY:
            begin
                emit           = 1'b1;
                emit_action    = ACT_DELAY;
                phase_next     = PH_IDLE;
                remaining_next = 8'd0;
                follow_next    = 2'd0;
            end
            default:
            begin
                phase_next     = PH_IDLE;
                remaining_next = 8'd0;
                follow_next    = 2'd0;
            end
        endcase
        if (last_byte)
        begin
            phase_next     = PH_IDLE;
            remaining_next = 8'd0;
            follow_next    = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 8'd0;
            follow_reg    <= 2'd0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            follow_reg    <= follow_next;
        end
    end

    assign push             = in_fire && emit;
    assign push_item.action = emit_action;
    assign push_item.value  = emit_value;

endmodule

// ===== rtl/core/dibi_queue.sv =====
// ---------------------------------------------------------------------------
// dibi_queue
// Small action queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module dibi_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dibi_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output dibi_pkg::item_t head_item
);
    import dibi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/dibi_back.sv =====
// ---------------------------------------------------------------------------
// dibi_back
// Output stage: registers the queue head onto the master-side stream.
// ---------------------------------------------------------------------------
module dibi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  dibi_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic [2:0]      m_axis_tuser
);
    import dibi_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign q_pop = q_not_empty && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_axis_tready)
        begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = item_reg.value;
    assign m_axis_tuser  = item_reg.action;

endmodule

// ===== rtl/core/display_init_batch_interpreter.sv =====
// ---------------------------------------------------------------------------
// display_init_batch_interpreter
// Decodes a byte-coded display set-up list into bus actions.
// ---------------------------------------------------------------------------
// Slave stream: one list byte per beat in tdata, tlast on the final byte of
// the list (the parser returns to idle after it).
// Master stream: one action per beat, tuser = action code (command, data,
// select, release, delay), tdata = byte to send or delay in ms.
// An input beat that yields an action is written into the queue at its
// accepting edge and passes through the output register to the master
// side. Throughput is one list byte per cycle while the queue has room;
// tready drops only when the QUEUE_DEPTH-entry queue between parser and
// output register is full, so a stalled receiver backs up into the slave
// side after QUEUE_DEPTH + 1 pending actions.
// Reset clears the parser to idle and empties the queue and output stage.
// ---------------------------------------------------------------------------
module display_init_batch_interpreter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] op_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [2:0] m_axis_tuser    // [2:0] action
);
    import dibi_pkg::*;

    logic  in_fire;
    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    item_t q_item;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    dibi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .op_byte   (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .push_item (push_item)
    );

    dibi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_item)
    );

    dibi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the display set-up list interpreter. List bytes
// go in as beats with random gaps; every action beat that comes out is
// compared in order against a behavioral decoder of the list format, with
// random back-pressure on the action stream.
// ---------------------------------------------------------------------------
module tb;
    import dibi_pkg::*;

    typedef enum logic [2:0] {
        LST_OPCODE,
        LST_CMD,
        LST_CMD_COUNT,
        LST_DATA_COUNT,
        LST_DATA,
        LST_DELAY
    } list_phase_t;

    localparam logic [1:0] FOLLOW_NONE  = 2'd0;
    localparam logic [1:0] FOLLOW_COUNT = 2'd3;
    localparam int         LIST_BEATS   = 1600;
    localparam logic [7:0] FIRST_UNKNOWN = OP_DELAY + 8'd1;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] op_byte
    logic       s_axis_tlast  = 1'b0;   // last_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] value
    logic [2:0] m_axis_tuser;           // [2:0] action

    list_phase_t lst_phase  = LST_OPCODE;
    logic [7:0]  lst_left   = 8'd0;
    logic [1:0]  lst_follow = FOLLOW_NONE;
    item_t       expected_actions[$];
    int          errors     = 0;
    int          list_beats = 0;
    bit          src_burst  = 1'b0;
    bit          sink_burst = 1'b0;

    always #5 clk = ~clk;

    display_init_batch_interpreter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic arm_parser(input list_phase_t ph, input logic [7:0] cnt,
                              input logic [1:0] fol);
        lst_phase  = ph;
        lst_left   = cnt;
        lst_follow = fol;
    endtask

    task automatic push_action(input action_t act, input logic [7:0] val);
        item_t it;
        it.action = act;
        it.value  = val;
        expected_actions.push_back(it);
    endtask

    task automatic decode_list_byte(input logic [7:0] b, input logic last);
        case (lst_phase)
            LST_OPCODE:
                case (b)
                    OP_SELECT:       push_action(ACT_SELECT, 8'd0);
                    OP_RELEASE:      push_action(ACT_RELEASE, 8'd0);
                    OP_CMD_ONE:      arm_parser(LST_CMD, 8'd1, FOLLOW_NONE);
                    OP_CMD_TWO:      arm_parser(LST_CMD, 8'd2, FOLLOW_NONE);
                    OP_CMD_RUN:      arm_parser(LST_CMD_COUNT, 8'd0, FOLLOW_NONE);
                    OP_DATA_ONE:     arm_parser(LST_DATA, 8'd1, FOLLOW_NONE);
                    OP_DATA_TWO:     arm_parser(LST_DATA, 8'd2, FOLLOW_NONE);
                    OP_DATA_RUN:     arm_parser(LST_DATA_COUNT, 8'd0, FOLLOW_NONE);
                    OP_CMD_DATA_ONE: arm_parser(LST_CMD, 8'd1, 2'd1);
                    OP_CMD_DATA_TWO: arm_parser(LST_CMD, 8'd1, 2'd2);
                    OP_CMD_DATA_RUN: arm_parser(LST_CMD, 8'd1, FOLLOW_COUNT);
                    OP_CMD2_DATA2:   arm_parser(LST_CMD, 8'd2, 2'd2);
                    OP_DELAY:        arm_parser(LST_DELAY, 8'd0, FOLLOW_NONE);
                    default: ;
                endcase
            LST_CMD:
            begin
                push_action(ACT_CMD, b);
                lst_left = lst_left - 8'd1;
                if (lst_left == 8'd0)
                begin
                    if (lst_follow == FOLLOW_NONE)
                        arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
                    else if (lst_follow == FOLLOW_COUNT)
                        arm_parser(LST_DATA_COUNT, 8'd0, FOLLOW_NONE);
                    else
                        arm_parser(LST_DATA, {6'd0, lst_follow}, FOLLOW_NONE);
                end
            end
            LST_CMD_COUNT, LST_DATA_COUNT:
            begin
                if (b == 8'd0)
                    arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
                else if (lst_phase == LST_CMD_COUNT)
                    arm_parser(LST_CMD, b, FOLLOW_NONE);
                else
                    arm_parser(LST_DATA, b, FOLLOW_NONE);
            end
            LST_DATA:
            begin
                push_action(ACT_DATA, b);
                lst_left = lst_left - 8'd1;
                if (lst_left == 8'd0)
                    arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
            end
            LST_DELAY:
            begin
                push_action(ACT_DELAY, b);
                arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
            end
            default: arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
        endcase
        if (last)
            arm_parser(LST_OPCODE, 8'd0, FOLLOW_NONE);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_list_byte(b, last);
    endtask

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 49);
        if (r < 3)
            return 8'd0;
        if (r < 5)
            return 8'($urandom_range(7, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic send_random_op();
        logic [7:0] op_beats[$];
        logic [7:0] opc;
        logic [7:0] cnt;
        logic       end_list;
        int         cut;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            send_byte(8'($urandom_range(int'(FIRST_UNKNOWN), 255)),
                      $urandom_range(0, 7) == 0);
            return;
        end
        opc = 8'($urandom_range(int'(OP_SELECT), int'(OP_DELAY)));
        op_beats.push_back(opc);
        case (opc)
            OP_CMD_ONE, OP_DATA_ONE, OP_DELAY:
                op_beats.push_back(8'($urandom_range(0, 255)));
            OP_CMD_TWO, OP_DATA_TWO, OP_CMD_DATA_ONE:
                repeat (2) op_beats.push_back(8'($urandom_range(0, 255)));
            OP_CMD_DATA_TWO:
                repeat (3) op_beats.push_back(8'($urandom_range(0, 255)));
            OP_CMD2_DATA2:
                repeat (4) op_beats.push_back(8'($urandom_range(0, 255)));
            OP_CMD_RUN, OP_DATA_RUN, OP_CMD_DATA_RUN:
            begin
                if (opc == OP_CMD_DATA_RUN)
                    op_beats.push_back(8'($urandom_range(0, 255)));
                cnt = pick_count();
                op_beats.push_back(cnt);
                repeat (cnt) op_beats.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        // broken list: tlast lands somewhere inside the operation
        cut = op_beats.size() - 1;
        if (r < 14)
            cut = $urandom_range(0, op_beats.size() - 1);
        end_list = (r < 14) || (opc == OP_RELEASE && $urandom_range(0, 1) == 1);
        for (int i = 0; i <= cut; i++)
            send_byte(op_beats[i], end_list && (i == cut));
        list_beats += cut + 1;
    endtask

    task automatic test_opcodes();
        send_byte(OP_SELECT, 1'b0);
        send_byte(OP_CMD_ONE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(OP_CMD_TWO, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(OP_CMD_RUN, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(OP_DATA_ONE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_DATA_TWO, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(OP_DATA_RUN, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(OP_CMD_DATA_ONE, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(OP_CMD_DATA_TWO, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(OP_CMD_DATA_RUN, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(OP_CMD2_DATA2, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(OP_DELAY, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_RELEASE, 1'b1);
    endtask

    task automatic test_corner_cases();
        // unknown opcodes are skipped
        send_byte(FIRST_UNKNOWN, 1'b0);
        send_byte(8'hFF, 1'b1);
        // zero counts end the operation silently
        send_byte(OP_CMD_RUN, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(OP_DATA_RUN, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(OP_CMD_DATA_RUN, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'd0, 1'b0);
        // zero delay still emits
        send_byte(OP_DELAY, 1'b0);
        send_byte(8'd0, 1'b0);
        // tlast drops the unfinished operation
        send_byte(OP_DATA_TWO, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(OP_DATA_ONE, 1'b0);
        send_byte(8'h66, 1'b0);
    endtask

    task automatic test_random_lists();
        while (list_beats < LIST_BEATS)
            send_random_op();
    endtask

    initial
    begin : action_monitor
        int    stall;
        item_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (expected_actions.size() == 0)
            begin
                $error("unexpected action beat: action %0d value %0d",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_actions.pop_front();
                if (m_axis_tuser !== want.action)
                begin
                    $error("action: expected %0d, actual %0d", want.action, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_opcodes();
        test_corner_cases();
        test_random_lists();
        s_axis_tvalid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== display_init_batch_interpreter.f =====
rtl/core/dibi_pkg.sv
rtl/core/dibi_front.sv
rtl/core/dibi_queue.sv
rtl/core/dibi_back.sv
rtl/core/display_init_batch_interpreter.sv
bench/tb.sv
